>>> rtl/core/dual_ultrasonic_proximity_alarm_assert.svh
// assertion helpers for the proximity alarm
`ifndef DUAL_ULTRASONIC_PROXIMITY_ALARM_ASSERT_SVH
`define DUAL_ULTRASONIC_PROXIMITY_ALARM_ASSERT_SVH

// implication checked every edge outside reset
`define DUP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// invariant checked every edge outside reset
`define DUP_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("invariant check failed");

`endif

>>> rtl/core/dup_pkg.sv
`default_nettype none
package dup_pkg;

  typedef enum logic [1:0] {
    ZONE_SAFE    = 2'd0,
    ZONE_WARNING = 2'd1,
    ZONE_DANGER  = 2'd2
  } zone_t;

  localparam logic [2:0] CFG_DANGER_LIMIT  = 3'd0;
  localparam logic [2:0] CFG_WARNING_LIMIT = 3'd1;
  localparam logic [2:0] CFG_VOTE_THRESH   = 3'd2;
  localparam logic [2:0] CFG_MIN_ECHO      = 3'd3;
  localparam logic [2:0] CFG_MAX_ECHO      = 3'd4;

  localparam logic [9:0]  RST_DANGER_LIMIT  = 10'd50;
  localparam logic [9:0]  RST_WARNING_LIMIT = 10'd100;
  localparam logic [6:0]  RST_VOTE_THRESH   = 7'd5;
  localparam logic [15:0] RST_MIN_ECHO      = 16'd100;
  localparam logic [15:0] RST_MAX_ECHO      = 16'd30000;

  localparam logic [9:0] NO_READING = 10'd999;

  // ceil(2^22 / 58), exact quotient for any 16-bit echo
  localparam logic [16:0] CM_RECIP = 17'd72316;
  localparam int          CM_SHIFT = 22;

  localparam logic [7:0] LED_FULL = 8'd255;
  localparam logic [7:0] LED_AMBER_GREEN = 8'd180;
  localparam logic [7:0] LED_OFF = 8'd0;

  localparam logic [1:0] ALERT_NONE    = 2'd0;
  localparam logic [1:0] ALERT_WARNING = 2'd1;
  localparam logic [1:0] ALERT_DANGER  = 2'd2;

  localparam logic [1:0] BEEPS_NONE    = 2'd0;
  localparam logic [1:0] BEEPS_WARNING = 2'd1;
  localparam logic [1:0] BEEPS_DANGER  = 2'd2;

  typedef struct packed {
    logic [15:0] min_us;
    logic [15:0] max_us;
  } echo_bounds_t;

endpackage
`default_nettype wire

>>> rtl/core/dual_ultrasonic_proximity_alarm.sv
// Proximity alarm for two ultrasonic sensors. Each request is one measurement round; it
// is turned into two distances, the nearer one is classed as safe, warning or danger and
// voted over a window of the last WINDOW_DEPTH rounds held in a small ring RAM. The block
// takes one request per clock cycle while the output is not stalled. Acceptance registers
// the round and starts the registered read of the class ring; the compute stage then
// converts, classes, updates the tallies, writes the ring entry back and loads the output
// register. A stalled output holds the compute stage, so ready falls once both
// hold a round. After reset the ring reads as all safe at once through per-entry valid
// flags; there is no clearing pass. Write configuration only while no round is in flight.
`default_nettype none
`include "dual_ultrasonic_proximity_alarm_assert.svh"
module dual_ultrasonic_proximity_alarm #(
  parameter int WINDOW_DEPTH = 10
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_button_pressed,
  input  wire logic        in_echo_up_valid,
  input  wire logic [15:0] in_echo_up_us,
  input  wire logic        in_echo_down_valid,
  input  wire logic [15:0] in_echo_down_us,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [9:0]  out_dist_up_cm,
  output logic      [9:0]  out_dist_down_cm,
  output logic      [9:0]  out_nearest_cm,
  output logic      [1:0]  out_zone,
  output logic      [7:0]  out_red_level,
  output logic      [7:0]  out_green_level,
  output logic      [7:0]  out_blue_level,
  output logic      [1:0]  out_beep_count,
  output logic             out_enabled,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);
  import dup_pkg::*;

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int TW = $clog2(WINDOW_DEPTH + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(WINDOW_DEPTH - 1);
  localparam logic [TW-1:0] DEPTH_CNT = TW'(WINDOW_DEPTH);

  // configuration
  logic [9:0]  danger_limit_r, warning_limit_r;
  logic [6:0]  vote_thresh_r;
  logic [15:0] min_echo_r, max_echo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      danger_limit_r  <= RST_DANGER_LIMIT;
      warning_limit_r <= RST_WARNING_LIMIT;
      vote_thresh_r   <= RST_VOTE_THRESH;
      min_echo_r      <= RST_MIN_ECHO;
      max_echo_r      <= RST_MAX_ECHO;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DANGER_LIMIT:  danger_limit_r  <= cfg_wdata[9:0];
        CFG_WARNING_LIMIT: warning_limit_r <= cfg_wdata[9:0];
        CFG_VOTE_THRESH:   vote_thresh_r   <= cfg_wdata[6:0];
        CFG_MIN_ECHO:      min_echo_r      <= cfg_wdata;
        CFG_MAX_ECHO:      max_echo_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  echo_bounds_t bounds;
  assign bounds = '{min_us: min_echo_r, max_us: max_echo_r};

  // pipeline control
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r;
  logic s1_advance, in_accept;

  assign s1_advance = !out_valid_r || out_ready;
  assign in_ready   = !s1_valid_r || s1_advance;
  assign in_accept  = in_valid && in_ready;

  // ring pointer and per-entry valid flags
  logic [AW-1:0]           ptr_r, ptr_nxt;
  logic [WINDOW_DEPTH-1:0] ring_ok_r;

  always_comb begin
    ptr_nxt = ptr_r;
    if (in_accept) begin
      ptr_nxt = (ptr_r == LAST_ADDR) ? '0 : ptr_r + AW'(1);
    end
  end

  // stage one registers
  logic          s1_button_r, s1_up_valid_r, s1_down_valid_r, s1_old_ok_r;
  logic [15:0]   s1_up_us_r, s1_down_us_r;
  logic [AW-1:0] s1_addr_r;
  logic [1:0]    ring_rdata;
  logic          s1_write;

  assign s1_valid_nxt = in_accept || (s1_valid_r && !s1_advance);
  assign s1_write     = s1_valid_r && s1_advance;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_button_r     <= in_button_pressed;
      s1_up_valid_r   <= in_echo_up_valid;
      s1_up_us_r      <= in_echo_up_us;
      s1_down_valid_r <= in_echo_down_valid;
      s1_down_us_r    <= in_echo_down_us;
      s1_addr_r       <= ptr_r;
      s1_old_ok_r     <= ring_ok_r[ptr_r];
    end
  end

  // compute stage
  logic [9:0]    up_cm, down_cm, near_cm;
  zone_t         old_zone, new_zone;
  logic [TW-1:0] danger_tally_r, danger_tally_nxt;
  logic [TW-1:0] warning_tally_r, warning_tally_nxt;
  logic [1:0]    alert_r, alert_nxt;
  logic          enable_r, enable_nxt;
  logic [7:0]    red_v, green_v, blue_v;
  logic [1:0]    beeps_v;

  dup_echo_cm u_cm_up (
    .echo_valid (s1_up_valid_r),
    .echo_us    (s1_up_us_r),
    .bounds     (bounds),
    .dist_cm    (up_cm)
  );

  dup_echo_cm u_cm_down (
    .echo_valid (s1_down_valid_r),
    .echo_us    (s1_down_us_r),
    .bounds     (bounds),
    .dist_cm    (down_cm)
  );

  dup_ram #(
    .WIDTH (2),
    .DEPTH (WINDOW_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (s1_write),
    .waddr (s1_addr_r),
    .wdata (new_zone),
    .re    (in_accept),
    .raddr (ptr_r),
    .rdata (ring_rdata)
  );

  always_comb begin
    near_cm = (up_cm < down_cm) ? up_cm : down_cm;
    case (ring_rdata)
      ZONE_WARNING: old_zone = ZONE_WARNING;
      ZONE_DANGER:  old_zone = ZONE_DANGER;
      default:      old_zone = ZONE_SAFE;
    endcase
    if (!s1_old_ok_r) begin
      old_zone = ZONE_SAFE;
    end

    danger_tally_nxt  = danger_tally_r;
    warning_tally_nxt = warning_tally_r;
    if (old_zone == ZONE_DANGER && danger_tally_r != '0) begin
      danger_tally_nxt = danger_tally_r - TW'(1);
    end else if (old_zone == ZONE_WARNING && warning_tally_r != '0) begin
      warning_tally_nxt = warning_tally_r - TW'(1);
    end

    if (near_cm <= danger_limit_r) begin
      new_zone         = ZONE_DANGER;
      danger_tally_nxt = danger_tally_nxt + TW'(1);
    end else if (near_cm <= warning_limit_r) begin
      new_zone          = ZONE_WARNING;
      warning_tally_nxt = warning_tally_nxt + TW'(1);
    end else begin
      new_zone = ZONE_SAFE;
    end

    enable_nxt = enable_r ^ s1_button_r;
    alert_nxt  = alert_r;
    red_v      = LED_OFF;
    green_v    = LED_OFF;
    blue_v     = LED_OFF;
    beeps_v    = BEEPS_NONE;
    if (enable_nxt) begin
      if (7'(danger_tally_nxt) > vote_thresh_r) begin
        red_v     = LED_FULL;
        beeps_v   = (alert_r < ALERT_DANGER) ? BEEPS_DANGER : BEEPS_NONE;
        alert_nxt = ALERT_DANGER;
      end else if (7'(warning_tally_nxt) > vote_thresh_r) begin
        red_v     = LED_FULL;
        green_v   = LED_AMBER_GREEN;
        beeps_v   = (alert_r < ALERT_WARNING) ? BEEPS_WARNING : BEEPS_NONE;
        alert_nxt = ALERT_WARNING;
      end else begin
        green_v   = LED_FULL;
        alert_nxt = ALERT_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      ptr_r           <= '0;
      ring_ok_r       <= '0;
      danger_tally_r  <= '0;
      warning_tally_r <= '0;
      alert_r         <= ALERT_NONE;
      enable_r        <= 1'b1;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      ptr_r      <= ptr_nxt;
      if (s1_advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_write) begin
        ring_ok_r[s1_addr_r] <= 1'b1;
        danger_tally_r       <= danger_tally_nxt;
        warning_tally_r      <= warning_tally_nxt;
        alert_r              <= alert_nxt;
        enable_r             <= enable_nxt;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (s1_write) begin
      out_dist_up_cm   <= up_cm;
      out_dist_down_cm <= down_cm;
      out_nearest_cm   <= near_cm;
      out_zone         <= new_zone;
      out_red_level    <= red_v;
      out_green_level  <= green_v;
      out_blue_level   <= blue_v;
      out_beep_count   <= beeps_v;
      out_enabled      <= enable_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `DUP_ASSERT_ALWAYS(a_tally_bound, clk, rst_n,
    ({1'b0, danger_tally_r} + {1'b0, warning_tally_r}) <= {1'b0, DEPTH_CNT})
  `DUP_ASSERT_IMPLY(a_stall_holds_s1, clk, rst_n, !in_ready, s1_valid_r && out_valid_r)
  `DUP_ASSERT_IMPLY(a_muted_dark, clk, rst_n, out_valid && !out_enabled,
    out_red_level == LED_OFF && out_green_level == LED_OFF && out_beep_count == BEEPS_NONE)
  `DUP_ASSERT_IMPLY(a_write_from_s1, clk, rst_n, s1_write, $past(s1_valid_nxt) || s1_valid_r)

endmodule
`default_nettype wire

>>> rtl/core/dup_ram.sv
`default_nettype none
module dup_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 10
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/dup_echo_cm.sv
`default_nettype none
module dup_echo_cm (
  input  wire logic                  echo_valid,
  input  wire logic [15:0]           echo_us,
  input  wire dup_pkg::echo_bounds_t bounds,
  output logic      [9:0]            dist_cm
);
  import dup_pkg::*;

  logic [32:0] prod;
  logic [10:0] quot;
  logic        in_range;

  always_comb begin
    prod     = {17'd0, echo_us} * {16'd0, CM_RECIP};
    quot     = prod[CM_SHIFT+10:CM_SHIFT];
    in_range = echo_valid && (echo_us > bounds.min_us) && (echo_us < bounds.max_us);
    if (!in_range || quot > {1'b0, NO_READING}) begin
      dist_cm = NO_READING;
    end else begin
      dist_cm = quot[9:0];
    end
  end

endmodule
`default_nettype wire

>>> tb/sv/dual_ultrasonic_proximity_alarm_test.sv
module dual_ultrasonic_proximity_alarm_test;
  import dup_pkg::*;

  localparam int WINDOW = 10;
  localparam logic [15:0] CM_DIVISOR = 16'd58;
  localparam int SETTLE_CYCLES = 4;
  localparam int BLOCK_ROUNDS = 45;
  localparam int BLOCKS = 9;
  localparam int REPORT_LIMIT = 10;
  localparam int PLAN_LEN = 37;

  localparam logic [2:0] CFG_SPARE_A = 3'd5;
  localparam logic [2:0] CFG_SPARE_B = 3'd6;
  localparam logic [2:0] CFG_SPARE_C = 3'd7;

  typedef struct packed {
    logic        button;
    logic        up_ok;
    logic [15:0] up_us;
    logic        down_ok;
    logic [15:0] down_us;
  } round_t;

  typedef struct packed {
    logic [9:0] up_cm;
    logic [9:0] down_cm;
    logic [9:0] near_cm;
    zone_t      zone;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [1:0] beeps;
    logic       on;
  } alarm_t;

  typedef enum logic {ROW_ROUND, ROW_SETTING} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [2:0]  idx;
    logic [15:0] value;
    round_t      round;
    logic        typed;
    alarm_t      want;
  } row_t;

  localparam alarm_t IDLE_SAFE = '{NO_READING, NO_READING, NO_READING, ZONE_SAFE,
                                   LED_OFF, LED_FULL, LED_OFF, BEEPS_NONE, 1'b1};
  localparam alarm_t IDLE_MUTED = '{NO_READING, NO_READING, NO_READING, ZONE_SAFE,
                                    LED_OFF, LED_OFF, LED_OFF, BEEPS_NONE, 1'b0};
  localparam alarm_t UNTYPED = '0;
  localparam round_t NO_ROUND = '0;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_button_pressed = 1'b0;
  logic        in_echo_up_valid = 1'b0;
  logic [15:0] in_echo_up_us = '0;
  logic        in_echo_down_valid = 1'b0;
  logic [15:0] in_echo_down_us = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [9:0]  out_dist_up_cm;
  logic [9:0]  out_dist_down_cm;
  logic [9:0]  out_nearest_cm;
  logic [1:0]  out_zone;
  logic [7:0]  out_red_level;
  logic [7:0]  out_green_level;
  logic [7:0]  out_blue_level;
  logic [1:0]  out_beep_count;
  logic        out_enabled;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = CFG_DANGER_LIMIT;
  logic [15:0] cfg_wdata = '0;

  dual_ultrasonic_proximity_alarm dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_button_pressed  (in_button_pressed),
    .in_echo_up_valid   (in_echo_up_valid),
    .in_echo_up_us      (in_echo_up_us),
    .in_echo_down_valid (in_echo_down_valid),
    .in_echo_down_us    (in_echo_down_us),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_dist_up_cm     (out_dist_up_cm),
    .out_dist_down_cm   (out_dist_down_cm),
    .out_nearest_cm     (out_nearest_cm),
    .out_zone           (out_zone),
    .out_red_level      (out_red_level),
    .out_green_level    (out_green_level),
    .out_blue_level     (out_blue_level),
    .out_beep_count     (out_beep_count),
    .out_enabled        (out_enabled),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // alarm state as the testbench sees it
  logic [9:0]  danger_limit;
  logic [9:0]  warning_limit;
  logic [6:0]  vote_min;
  logic [15:0] echo_floor;
  logic [15:0] echo_ceiling;
  zone_t       zone_ring [WINDOW];
  int          ring_ptr;
  int          danger_tally;
  int          warning_tally;
  logic [1:0]  alert_now;
  logic        alarm_on;

  alarm_t alarm_expect_q [$];
  logic   typed_now = 1'b0;
  alarm_t typed_want = '0;

  int send_idle_pct = 36;
  int recv_idle_pct = 46;
  int rounds_taken = 0;
  int results_seen = 0;
  int fail_count = 0;
  int reg_writes = 0;
  int red_results = 0;
  int beep_results = 0;
  int muted_results = 0;
  int scene_cm = 80;

  row_t plan [PLAN_LEN] = '{
    '{ROW_ROUND, CFG_DANGER_LIMIT, 16'd0, '{0, 0, 16'd0, 0, 16'd0}, 1, IDLE_SAFE},
    '{ROW_ROUND, CFG_DANGER_LIMIT, 16'd0, '{0, 1, 16'hFFFF, 1, 16'hFFFF}, 1, IDLE_SAFE},
    '{ROW_ROUND, CFG_DANGER_LIMIT, 16'd0, '{0, 1, 16'd0, 1, 16'd0}, 1, IDLE_SAFE},
    '{ROW_ROUND, CFG_DANGER_LIMIT, 16'd0, '{0, 1, 16'd100, 1, 16'd30000}, 1, IDLE_SAFE},
    '{ROW_ROUND, CFG_DANGER_LIMIT, 16'd0, '{1, 0, 16'd0, 0, 16'd0}, 1, IDLE_MUTED},
    '{ROW_ROUND, CFG_DANGER_LIMIT, 16'd0, '{1, 0, 16'd0, 0, 16'd0}, 1, IDLE_SAFE},
    '{ROW_ROUND, CFG_DANGER_LIMIT, 16'd0, '{0, 1, 16'd101, 0, 16'd0}, 0, UNTYPED},
    '{ROW_ROUND, CFG_DANGER_LIMIT, 16'd0, '{0, 0, 16'd0, 1, 16'd29999}, 0, UNTYPED},
    '{ROW_ROUND, CFG_DANGER_LIMIT, 16'd0, '{0, 1, 16'd5800, 1, 16'd5858}, 0, UNTYPED},
    '{ROW_ROUND, CFG_DANGER_LIMIT, 16'd0, '{0, 1, 16'd2900, 0, 16'hAAAA}, 0, UNTYPED},
    '{ROW_ROUND, CFG_DANGER_LIMIT, 16'd0, '{0, 1, 16'd2900, 0, 16'hAAAA}, 0, UNTYPED},
    '{ROW_ROUND, CFG_DANGER_LIMIT, 16'd0, '{0, 1, 16'd2900, 0, 16'hAAAA}, 0, UNTYPED},
    '{ROW_ROUND, CFG_DANGER_LIMIT, 16'd0, '{0, 1, 16'd2900, 0, 16'hAAAA}, 0, UNTYPED},
    '{ROW_ROUND, CFG_DANGER_LIMIT, 16'd0, '{0, 1, 16'd2900, 0, 16'hAAAA}, 0, UNTYPED},
    '{ROW_ROUND, CFG_DANGER_LIMIT, 16'd0, '{1, 1, 16'd2900, 0, 16'hAAAA}, 0, UNTYPED},
    '{ROW_ROUND, CFG_DANGER_LIMIT, 16'd0, '{0, 1, 16'd2900, 0, 16'hAAAA}, 0, UNTYPED},
    '{ROW_ROUND, CFG_DANGER_LIMIT, 16'd0, '{1, 1, 16'd2900, 0, 16'hAAAA}, 0, UNTYPED},
    '{ROW_ROUND, CFG_DANGER_LIMIT, 16'd0, '{1, 1, 16'h5555, 1, 16'hAAAA}, 0, UNTYPED},
    '{ROW_ROUND, CFG_DANGER_LIMIT, 16'd0, '{1, 1, 16'hAAAA, 1, 16'h5555}, 0, UNTYPED},
    '{ROW_SETTING, CFG_MAX_ECHO, 16'hFFFF, NO_ROUND, 0, UNTYPED},
    '{ROW_SETTING, CFG_MIN_ECHO, 16'd0, NO_ROUND, 0, UNTYPED},
    '{ROW_ROUND, CFG_DANGER_LIMIT, 16'd0, '{0, 1, 16'd65534, 1, 16'd64000}, 0, UNTYPED},
    '{ROW_ROUND, CFG_DANGER_LIMIT, 16'd0, '{0, 1, 16'd1, 1, 16'd65534}, 0, UNTYPED},
    '{ROW_SETTING, CFG_DANGER_LIMIT, 16'd1023, NO_ROUND, 0, UNTYPED},
    '{ROW_SETTING, CFG_SPARE_A, 16'hFFFF, NO_ROUND, 0, UNTYPED},
    '{ROW_SETTING, CFG_SPARE_B, 16'hFFFF, NO_ROUND, 0, UNTYPED},
    '{ROW_SETTING, CFG_SPARE_C, 16'hFFFF, NO_ROUND, 0, UNTYPED},
    '{ROW_ROUND, CFG_DANGER_LIMIT, 16'd0, '{0, 0, 16'd0, 0, 16'd0}, 0, UNTYPED},
    '{ROW_SETTING, CFG_DANGER_LIMIT, 16'd0, NO_ROUND, 0, UNTYPED},
    '{ROW_SETTING, CFG_WARNING_LIMIT, 16'd1023, NO_ROUND, 0, UNTYPED},
    '{ROW_SETTING, CFG_VOTE_THRESH, 16'd0, NO_ROUND, 0, UNTYPED},
    '{ROW_ROUND, CFG_DANGER_LIMIT, 16'd0, '{0, 0, 16'hFFFF, 0, 16'hFFFF}, 0, UNTYPED},
    '{ROW_ROUND, CFG_DANGER_LIMIT, 16'd0, '{0, 1, 16'd57, 0, 16'd0}, 0, UNTYPED},
    '{ROW_SETTING, CFG_VOTE_THRESH, 16'd127, NO_ROUND, 0, UNTYPED},
    '{ROW_SETTING, CFG_WARNING_LIMIT, 16'd999, NO_ROUND, 0, UNTYPED},
    '{ROW_SETTING, CFG_DANGER_LIMIT, 16'd998, NO_ROUND, 0, UNTYPED},
    '{ROW_ROUND, CFG_DANGER_LIMIT, 16'd0, '{0, 0, 16'd0, 0, 16'd0}, 0, UNTYPED}
  };

  task automatic reset_alarm_state();
    danger_limit = RST_DANGER_LIMIT;
    warning_limit = RST_WARNING_LIMIT;
    vote_min = RST_VOTE_THRESH;
    echo_floor = RST_MIN_ECHO;
    echo_ceiling = RST_MAX_ECHO;
    foreach (zone_ring[i]) zone_ring[i] = ZONE_SAFE;
    ring_ptr = 0;
    danger_tally = 0;
    warning_tally = 0;
    alert_now = ALERT_NONE;
    alarm_on = 1'b1;
  endtask

  function automatic void store_setting(logic [2:0] idx, logic [15:0] data);
    case (idx)
      CFG_DANGER_LIMIT:  danger_limit = data[9:0];
      CFG_WARNING_LIMIT: warning_limit = data[9:0];
      CFG_VOTE_THRESH:   vote_min = data[6:0];
      CFG_MIN_ECHO:      echo_floor = data;
      CFG_MAX_ECHO:      echo_ceiling = data;
      default: ;
    endcase
  endfunction

  function automatic logic [9:0] echo_cm(logic ok, logic [15:0] us);
    logic [15:0] q;
    if (!ok || us <= echo_floor || us >= echo_ceiling) return NO_READING;
    q = us / CM_DIVISOR;
    // long echoes saturate to no reading
    return (q > NO_READING) ? NO_READING : q[9:0];
  endfunction

  function automatic alarm_t predict_alarm(round_t r);
    alarm_t a;
    zone_t gone;
    a = '0;
    if (r.button) alarm_on = ~alarm_on;
    a.up_cm = echo_cm(r.up_ok, r.up_us);
    a.down_cm = echo_cm(r.down_ok, r.down_us);
    a.near_cm = (a.up_cm < a.down_cm) ? a.up_cm : a.down_cm;

    gone = zone_ring[ring_ptr];
    if (gone == ZONE_DANGER && danger_tally > 0) danger_tally--;
    else if (gone == ZONE_WARNING && warning_tally > 0) warning_tally--;

    if (a.near_cm <= danger_limit) begin
      a.zone = ZONE_DANGER;
      danger_tally++;
    end else if (a.near_cm <= warning_limit) begin
      a.zone = ZONE_WARNING;
      warning_tally++;
    end else begin
      a.zone = ZONE_SAFE;
    end
    zone_ring[ring_ptr] = a.zone;
    ring_ptr = (ring_ptr + 1) % WINDOW;

    a.red = LED_OFF;
    a.green = LED_OFF;
    a.blue = LED_OFF;
    a.beeps = BEEPS_NONE;
    // muted rounds keep the alert level
    if (alarm_on) begin
      if (danger_tally > int'(vote_min)) begin
        a.red = LED_FULL;
        if (alert_now < ALERT_DANGER) a.beeps = BEEPS_DANGER;
        alert_now = ALERT_DANGER;
      end else if (warning_tally > int'(vote_min)) begin
        a.red = LED_FULL;
        a.green = LED_AMBER_GREEN;
        if (alert_now < ALERT_WARNING) a.beeps = BEEPS_WARNING;
        alert_now = ALERT_WARNING;
      end else begin
        a.green = LED_FULL;
        alert_now = ALERT_NONE;
      end
    end
    a.on = alarm_on;
    return a;
  endfunction

  function automatic void check_alarm(alarm_t got);
    alarm_t want;
    results_seen++;
    if (got.red != LED_OFF) red_results++;
    if (got.beeps != BEEPS_NONE) beep_results++;
    if (!got.on) muted_results++;
    if (alarm_expect_q.size() == 0) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
        $display("result %0d arrived with no request waiting: near=%0d zone=%0d",
                 results_seen, got.near_cm, got.zone);
      return;
    end
    want = alarm_expect_q.pop_front();
    if (got.up_cm !== want.up_cm || got.down_cm !== want.down_cm ||
        got.near_cm !== want.near_cm || got.zone !== want.zone ||
        got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
        got.beeps !== want.beeps || got.on !== want.on) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT) begin
        $display("result %0d expected up=%0d down=%0d near=%0d zone=%0d rgb=%0d,%0d,%0d",
                 results_seen, want.up_cm, want.down_cm, want.near_cm, want.zone,
                 want.red, want.green, want.blue, " beeps=%0d on=%0d", want.beeps, want.on);
        $display("  actual up=%0d down=%0d near=%0d zone=%0d rgb=%0d,%0d,%0d",
                 got.up_cm, got.down_cm, got.near_cm, got.zone,
                 got.red, got.green, got.blue, " beeps=%0d on=%0d", got.beeps, got.on);
      end
    end
  endfunction

  always @(posedge clk) begin : watch
    round_t taken;
    alarm_t guess;
    alarm_t seen;
    if (rst_n) begin
      if (cfg_we) store_setting(cfg_index, cfg_wdata);
      if (in_valid && in_ready) begin
        taken = '{in_button_pressed, in_echo_up_valid, in_echo_up_us,
                  in_echo_down_valid, in_echo_down_us};
        guess = predict_alarm(taken);
        alarm_expect_q.push_back(typed_now ? typed_want : guess);
        rounds_taken++;
      end
      if (out_valid && out_ready) begin
        seen = '{out_dist_up_cm, out_dist_down_cm, out_nearest_cm, zone_t'(out_zone),
                 out_red_level, out_green_level, out_blue_level, out_beep_count,
                 out_enabled};
        check_alarm(seen);
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_round(round_t r, logic typed, alarm_t want);
    int before_count;
    cfg_we <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    typed_now = typed;
    typed_want = want;
    in_valid <= 1'b1;
    in_button_pressed <= r.button;
    in_echo_up_valid <= r.up_ok;
    in_echo_up_us <= r.up_us;
    in_echo_down_valid <= r.down_ok;
    in_echo_down_us <= r.down_us;
    before_count = rounds_taken;
    // hold the request until it is taken
    do @(negedge clk); while (rounds_taken == before_count);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (alarm_expect_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    reg_writes++;
    @(negedge clk);
  endtask

  function automatic logic [15:0] random_echo();
    case ($urandom_range(9))
      0: return 16'($urandom);
      1: begin
        case ($urandom_range(3))
          0: return echo_floor;
          1: return echo_floor + 16'd1;
          2: return echo_ceiling - 16'd1;
          default: return echo_ceiling;
        endcase
      end
      default: return 16'((scene_cm + $urandom_range(0, 30)) * CM_DIVISOR
                          + $urandom_range(0, 57));
    endcase
  endfunction

  // an object drifts in front of both sensors, so votes build up
  function automatic round_t random_round();
    round_t r;
    if ($urandom_range(7) == 0) scene_cm = $urandom_range(0, 260);
    r.button = ($urandom_range(15) == 0);
    r.up_ok = ($urandom_range(9) != 0);
    r.up_us = random_echo();
    r.down_ok = ($urandom_range(9) != 0);
    r.down_us = random_echo();
    return r;
  endfunction

  task automatic random_settings(int block);
    logic [9:0]  dl;
    logic [9:0]  wl;
    logic [6:0]  vt;
    logic [15:0] lo;
    logic [15:0] hi;
    int          spread;
    if (block == 0) begin
      dl = RST_DANGER_LIMIT;
      wl = RST_WARNING_LIMIT;
      vt = RST_VOTE_THRESH;
      lo = RST_MIN_ECHO;
      hi = RST_MAX_ECHO;
    end else if (block == BLOCKS / 2) begin
      dl = 10'd0;
      wl = 10'd1023;
      vt = 7'd0;
      lo = 16'd0;
      hi = 16'hFFFF;
    end else begin
      case ($urandom_range(4))
        0: dl = 10'd0;
        1: dl = 10'd1023;
        default: dl = 10'($urandom_range(0, 200));
      endcase
      spread = int'(dl) + $urandom_range(0, 150);
      if ($urandom_range(3) == 0) wl = 10'($urandom_range(0, 1023));
      else wl = (spread > 1023) ? 10'd1023 : 10'(spread);
      if ($urandom_range(5) == 0) vt = $urandom_range(1) ? 7'd64 : 7'd127;
      else vt = 7'($urandom_range(0, 8));
      lo = ($urandom_range(5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400));
      hi = ($urandom_range(5) == 0) ? 16'hFFFF : 16'($urandom_range(6000, 40000));
    end
    wait_idle();
    write_reg(CFG_DANGER_LIMIT, 16'(dl));
    write_reg(CFG_WARNING_LIMIT, 16'(wl));
    write_reg(CFG_VOTE_THRESH, 16'(vt));
    write_reg(CFG_MIN_ECHO, lo);
    write_reg(CFG_MAX_ECHO, hi);
  endtask

  initial begin : stimulus
    int block;
    reset_alarm_state();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_SETTING) begin
        if (i == 0 || plan[i - 1].kind != ROW_SETTING) wait_idle();
        write_reg(plan[i].idx, plan[i].value);
      end else begin
        send_round(plan[i].round, plan[i].typed, plan[i].want);
      end
    end

    for (block = 0; block < BLOCKS; block++) begin
      case (block / 3)
        0: begin
          send_idle_pct = 36;
          recv_idle_pct = 46;
        end
        1: begin
          send_idle_pct = 46;
          recv_idle_pct = 36;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      random_settings(block);
      repeat (BLOCK_ROUNDS) send_round(random_round(), 1'b0, UNTYPED);
    end

    wait_idle();
    fail_count += alarm_expect_q.size();
    $display("%0d measurement rounds checked, %0d register writes across %0d setting blocks",
             results_seen, reg_writes, BLOCKS);
    $display("%0d rounds lit red, %0d sounded beeps, %0d ran muted",
             red_results, beep_results, muted_results);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
